// ===== hw/rtl/plc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise-linear curve lookup.
// Depends on nothing; every other file of the block uses it.
package plc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int FRAC_BITS   = 16;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 7;
	localparam int PIDX_W    = 6;
	localparam int SEG_W     = 6;
	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int DIV_W     = DATA_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int PRD_W     = 2 * DATA_W - FRAC_BITS;
	localparam int SUM_W     = PRD_W + 2;

	localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic REQ_QUERY = 1'b0;
	localparam logic REQ_LOAD  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_LAST,
		ST_CHK_FIRST,
		ST_SCAN,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_GET_LO,
		ST_SETUP,
		ST_DIV,
		ST_SLOPE,
		ST_MUL,
		ST_SUM
	} plc_state_t;

	typedef struct packed {
		logic              req_type;
		logic [PIDX_W-1:0] point_index;
		logic [DATA_W-1:0] point_flux_sq;
		logic [DATA_W-1:0] point_reluct;
		logic [DATA_W-1:0] query_flux_sq;
	} plc_req_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             capture_query;
		logic             cap_hi;
		logic             cap_lo;
		logic             setup;
		logic             base_hi;
		logic             div_start;
		logic             slope_en;
		logic             mul_en;
		logic             out_load;
		logic [IDX_W-1:0] seg;
	} plc_cmd_t;

	typedef struct packed {
		logic flux_ge;
		logic den_zero;
		logic div_done;
	} plc_status_t;

endpackage

// ===== hw/rtl/plc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, result and configuration.
// Depends on plc_pkg for field widths.
interface plc_in_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [plc_pkg::PIDX_W-1:0]     point_index;
	logic [plc_pkg::DATA_W-1:0]     point_flux_sq;
	logic [plc_pkg::DATA_W-1:0]     point_reluct;
	logic [plc_pkg::DATA_W-1:0]     query_flux_sq;

	modport source (output valid, req_type, point_index, point_flux_sq, point_reluct,
		query_flux_sq, input ready);
	modport sink (input valid, req_type, point_index, point_flux_sq, point_reluct,
		query_flux_sq, output ready);
endinterface

interface plc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [plc_pkg::DATA_W-1:0] reluct_value;
	logic signed [plc_pkg::DATA_W-1:0] reluct_slope;
	logic [plc_pkg::SEG_W-1:0]         segment_used;
	logic                              saturated;

	modport source (output valid, reluct_value, reluct_slope, segment_used, saturated,
		input ready);
	modport sink (input valid, reluct_value, reluct_slope, segment_used, saturated,
		output ready);
endinterface

interface plc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [plc_pkg::CNT_W-1:0] point_count;

	modport source (output valid, point_count, input ready);
	modport sink (input valid, point_count, output ready);
endinterface

// ===== hw/rtl/plc_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plc_pkg for widths.
module plc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [plc_pkg::DIV_W-1:0]    dividend,
	input  logic [plc_pkg::DATA_W-1:0]   divisor,
	output logic [plc_pkg::DIV_W-1:0]    quotient,
	output logic                         done
);
	import plc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    den_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/plc_datapath.sv =====
`timescale 1ns / 1ps
// Curve memory, segment registers, slope divide, interpolation and result register.
// Depends on plc_pkg and plc_div.
module plc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plc_pkg::plc_req_t             req,
	input  plc_pkg::plc_cmd_t             cmd,
	output plc_pkg::plc_status_t          status,
	output logic signed [plc_pkg::DATA_W-1:0] reluct_value,
	output logic signed [plc_pkg::DATA_W-1:0] reluct_slope,
	output logic [plc_pkg::SEG_W-1:0]     segment_used,
	output logic                          saturated
);
	import plc_pkg::*;

	logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
	logic [2*DATA_W-1:0] rd_q;

	logic [DATA_W-1:0]   b2_q;
	logic [DATA_W-1:0]   flux_hi_q, rel_hi_q, flux_lo_q, rel_lo_q;
	logic [DATA_W-1:0]   rel_base_q;
	logic [DATA_W-1:0]   dx_mag_q;
	logic                dx_neg_q;
	logic                q_neg_q;
	logic                zero_q;
	logic                sat_q;
	logic [DATA_W-1:0]   slope_q;
	logic [DATA_W-1:0]   slope_mag_q;
	logic                slope_neg_q;
	logic [2*DATA_W-1:0] prod_q;
	logic                prod_neg_q;
	logic [DATA_W-1:0]   val_q, slope_out_q;
	logic [SEG_W-1:0]    seg_q;
	logic                sat_out_q;

	logic [DATA_W-1:0]   rd_flux;
	logic                num_neg, den_neg;
	logic [DATA_W-1:0]   num_mag, den_mag;
	logic [DATA_W-1:0]   base_flux;
	logic [DIV_W-1:0]    quo;
	logic                div_done;
	logic                q_fits_pos, q_fits_neg;
	logic [PRD_W-1:0]    prd;
	logic signed [SUM_W-1:0] delta, sum;
	logic [SUM_W-DATA_W:0]   sum_top;
	logic                sum_fits;
	logic [DATA_W-1:0]   sum_clip;

	// Entries hold {flux, reluct}; a load beyond the table is dropped.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && ({1'b0, req.point_index} < (PIDX_W+1)'(TABLE_DEPTH)))
			mem[IDX_W'(req.point_index)] <= {req.point_flux_sq, req.point_reluct};
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rd_q <= mem[cmd.rd_addr];
	end

	always_comb begin
		rd_flux   = rd_q[2*DATA_W-1:DATA_W];
		num_neg   = rel_hi_q < rel_lo_q;
		num_mag   = num_neg ? rel_lo_q - rel_hi_q : rel_hi_q - rel_lo_q;
		den_neg   = flux_hi_q < flux_lo_q;
		den_mag   = den_neg ? flux_lo_q - flux_hi_q : flux_hi_q - flux_lo_q;
		base_flux = cmd.base_hi ? flux_hi_q : flux_lo_q;
	end

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({num_mag, {FRAC_BITS{1'b0}}}),
		.divisor  (den_mag),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		q_fits_pos = quo[DIV_W-1:DATA_W-1] == '0;
		q_fits_neg = q_fits_pos ||
			((quo[DIV_W-1:DATA_W] == '0) && (quo[DATA_W-2:0] == '0));
	end

	always_comb begin
		prd     = prod_q[2*DATA_W-1:FRAC_BITS];
		delta   = zero_q ? '0 :
			(prod_neg_q ? -$signed({2'b00, prd}) : $signed({2'b00, prd}));
		sum     = $signed({{(SUM_W-DATA_W){1'b0}}, rel_base_q}) + delta;
		sum_top = sum[SUM_W-1:DATA_W-1];
		sum_fits = (&sum_top) || !(|sum_top);
		sum_clip = sum_fits ? sum[DATA_W-1:0] : (sum[SUM_W-1] ? S_MIN : S_MAX);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_query)
			b2_q <= req.query_flux_sq;
		if (cmd.cap_hi) begin
			flux_hi_q <= rd_q[2*DATA_W-1:DATA_W];
			rel_hi_q  <= rd_q[DATA_W-1:0];
		end
		if (cmd.cap_lo) begin
			flux_lo_q <= rd_q[2*DATA_W-1:DATA_W];
			rel_lo_q  <= rd_q[DATA_W-1:0];
		end
		if (cmd.setup) begin
			rel_base_q <= cmd.base_hi ? rel_hi_q : rel_lo_q;
			dx_neg_q   <= b2_q < base_flux;
			dx_mag_q   <= (b2_q < base_flux) ? base_flux - b2_q : b2_q - base_flux;
			q_neg_q    <= num_neg ^ den_neg;
			zero_q     <= flux_hi_q == flux_lo_q;
			sat_q      <= 1'b0;
		end
		if (cmd.slope_en) begin
			if (!q_neg_q) begin
				slope_q     <= q_fits_pos ? quo[DATA_W-1:0] : S_MAX;
				slope_mag_q <= q_fits_pos ? quo[DATA_W-1:0] : S_MAX;
				slope_neg_q <= 1'b0;
				sat_q       <= !q_fits_pos;
			end else begin
				slope_q     <= q_fits_neg ? -quo[DATA_W-1:0] : S_MIN;
				slope_mag_q <= q_fits_neg ? quo[DATA_W-1:0] : S_MIN;
				slope_neg_q <= 1'b1;
				sat_q       <= !q_fits_neg;
			end
		end
		if (cmd.mul_en) begin
			prod_q     <= slope_mag_q * dx_mag_q;
			prod_neg_q <= slope_neg_q ^ dx_neg_q;
		end
		if (cmd.out_load) begin
			val_q       <= sum_clip;
			slope_out_q <= zero_q ? '0 : slope_q;
			seg_q       <= SEG_W'(cmd.seg);
			sat_out_q   <= sat_q || zero_q || !sum_fits;
		end
	end

	always_comb begin
		status.flux_ge  = b2_q >= rd_flux;
		status.den_zero = flux_hi_q == flux_lo_q;
		status.div_done = div_done;
	end

	assign reluct_value = $signed(val_q);
	assign reluct_slope = $signed(slope_out_q);
	assign segment_used = seg_q;
	assign saturated    = sat_out_q;

endmodule

// ===== hw/rtl/plc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: breakpoint search, operand fetch, divide/multiply steps, result handoff.
// Depends on plc_pkg; drives plc_datapath through command and status structs.
module plc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_req_type,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [plc_pkg::CNT_W-1:0]  cfg_data,
	output plc_pkg::plc_cmd_t          cmd,
	input  plc_pkg::plc_status_t       status
);
	import plc_pkg::*;

	plc_state_t       state_q, state_d;
	logic [CNT_W-1:0] point_count_q;
	logic [IDX_W-1:0] last_q, last_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] hi_q;
	logic             base_hi_q;
	logic             out_valid_q;
	logic             accept, query_acc;
	logic             scan_hit;

	// Clamp the breakpoint count to 2..TABLE_DEPTH, keep index of the last one.
	always_comb begin
		if (point_count_q < CNT_W'(2))
			last_d = IDX_W'(1);
		else if (int'(point_count_q) > TABLE_DEPTH)
			last_d = IDX_W'(TABLE_DEPTH - 1);
		else
			last_d = IDX_W'(point_count_q - CNT_W'(1));
	end

	always_comb begin
		accept    = in_valid && (state_q == ST_IDLE);
		query_acc = accept && (in_req_type == REQ_QUERY);
		scan_hit  = !status.flux_ge || (idx_q == last_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (query_acc) state_d = ST_CHK_LAST;
			ST_CHK_LAST:  state_d = status.flux_ge ? ST_FETCH_HI : ST_CHK_FIRST;
			ST_CHK_FIRST: state_d = status.flux_ge ? ST_SCAN : ST_FETCH_HI;
			ST_SCAN:      if (scan_hit) state_d = ST_FETCH_HI;
			ST_FETCH_HI:  state_d = ST_FETCH_LO;
			ST_FETCH_LO:  state_d = ST_GET_LO;
			ST_GET_LO:    state_d = ST_SETUP;
			ST_SETUP:     state_d = status.den_zero ? ST_SUM : ST_DIV;
			ST_DIV:       if (status.div_done) state_d = ST_SLOPE;
			ST_SLOPE:     state_d = ST_MUL;
			ST_MUL:       state_d = ST_SUM;
			ST_SUM:       if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.base_hi = base_hi_q;
		cmd.seg     = hi_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready          = 1'b1;
				cmd.wr_en         = accept && (in_req_type == REQ_LOAD);
				cmd.rd_en         = query_acc;
				cmd.rd_addr       = last_d;
				cmd.capture_query = query_acc;
			end
			ST_CHK_LAST: begin
				cmd.rd_en   = !status.flux_ge;
				cmd.rd_addr = '0;
			end
			ST_CHK_FIRST: begin
				cmd.rd_en   = status.flux_ge;
				cmd.rd_addr = IDX_W'(1);
			end
			ST_SCAN: begin
				// look one entry ahead while comparing the current one
				cmd.rd_en   = !scan_hit;
				cmd.rd_addr = idx_q + IDX_W'(1);
			end
			ST_FETCH_HI: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = hi_q;
			end
			ST_FETCH_LO: begin
				cmd.cap_hi  = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = hi_q - IDX_W'(1);
			end
			ST_GET_LO:    cmd.cap_lo = 1'b1;
			ST_SETUP: begin
				cmd.setup     = 1'b1;
				cmd.div_start = !status.den_zero;
			end
			ST_DIV:       cmd.slope_en = 1'b0;
			ST_SLOPE:     cmd.slope_en = 1'b1;
			ST_MUL:       cmd.mul_en = 1'b1;
			ST_SUM:       cmd.out_load = !out_valid_q || out_ready;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= CNT_W'(2);
			last_q        <= IDX_W'(1);
			idx_q         <= '0;
			hi_q          <= IDX_W'(1);
			base_hi_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				point_count_q <= cfg_data;
			if (query_acc)
				last_q <= last_d;
			unique case (state_q)
				ST_CHK_LAST: begin
					if (status.flux_ge) begin
						hi_q      <= last_q;
						base_hi_q <= 1'b1;
					end
				end
				ST_CHK_FIRST: begin
					if (status.flux_ge) begin
						idx_q <= IDX_W'(1);
					end else begin
						hi_q      <= IDX_W'(1);
						base_hi_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						hi_q      <= idx_q;
						base_hi_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== hw/rtl/piecewise_linear_curve_lookup.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// in_ch     in   load: point_index, point_flux_sq, point_reluct; query: query_flux_sq
// out_ch    out  reluct_value, reluct_slope, segment_used, saturated (one per query)
// cfg_ch    in   point_count
// A load beat gives no result. A query runs the breakpoint search, one memory read per
// cycle, then the bit-serial slope divide, multiply and sum; a zero-width segment skips
// the divide and multiply.
// arst_n clears control state and sets point_count to 2; curve entries are not cleared.
// A result waits in the output register; the next beat is taken while it waits.
module piecewise_linear_curve_lookup (
	input logic      clk,
	input logic      arst_n,
	plc_in_if.sink   in_ch,
	plc_out_if.source out_ch,
	plc_cfg_if.sink  cfg_ch
);
	import plc_pkg::*;

	plc_req_t    req;
	plc_cmd_t    cmd;
	plc_status_t status;

	always_comb begin
		req.req_type      = in_ch.req_type;
		req.point_index   = in_ch.point_index;
		req.point_flux_sq = in_ch.point_flux_sq;
		req.point_reluct  = in_ch.point_reluct;
		req.query_flux_sq = in_ch.query_flux_sq;
	end

	plc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_req_type (in_ch.req_type),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.cfg_valid   (cfg_ch.valid),
		.cfg_ready   (cfg_ch.ready),
		.cfg_data    (cfg_ch.point_count),
		.cmd         (cmd),
		.status      (status)
	);

	plc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.status       (status),
		.reluct_value (out_ch.reluct_value),
		.reluct_slope (out_ch.reluct_slope),
		.segment_used (out_ch.segment_used),
		.saturated    (out_ch.saturated)
	);

`ifndef SYNTHESIS
	// a query beat blocks the input for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && (in_ch.req_type == REQ_QUERY) |=> !in_ch.ready)
		else $error("input taken while a query is in flight");

	// never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_ch.valid || out_ch.ready))
		else $error("pending result overwritten");

	// no divide is started on a zero-width segment
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.den_zero)
		else $error("divide started on zero-width segment");

	// the divider finishes exactly while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !in_ch.ready && !cmd.out_load)
		else $error("divider done outside divide step");
`endif

endmodule

// ===== bench/piecewise_linear_curve_lookup_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the piecewise-linear reluctivity curve lookup: loads curves,
// sweeps queries and point counts under varied idling, and checks every result beat.
// Depends on plc_pkg, the plc_*_if interfaces and the piecewise_linear_curve_lookup RTL.
module piecewise_linear_curve_lookup_test;
	import plc_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] slope;
		logic [SEG_W-1:0]         seg;
		logic                     sat;
	} curve_result_t;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	class reluct_curve_predictor;
		logic [DATA_W-1:0] flux_tab [TABLE_DEPTH];
		logic [DATA_W-1:0] reluct_tab [TABLE_DEPTH];
		logic [CNT_W-1:0]  point_count;
		curve_result_t     expected_lookups [$];
		int                mismatches;

		function new();
			point_count = CNT_W'(2);
			mismatches = 0;
			foreach (flux_tab[k]) begin
				flux_tab[k] = '0;
				reluct_tab[k] = '0;
			end
		endfunction

		function int unsigned points_in_use();
			if (point_count < 2)
				return 2;
			if (point_count > TABLE_DEPTH)
				return TABLE_DEPTH;
			return point_count;
		endfunction

		function void set_point_count(logic [CNT_W-1:0] v);
			point_count = v;
		endfunction

		function longint widen(logic [DATA_W-1:0] x);
			return longint'({32'd0, x});
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? $unsigned(-v) : $unsigned(v);
		endfunction

		function longint clip32(longint v, inout bit clipped);
			if (v > S32_MAX) begin
				clipped = 1'b1;
				return S32_MAX;
			end
			if (v < S32_MIN) begin
				clipped = 1'b1;
				return S32_MIN;
			end
			return v;
		endfunction

		function curve_result_t lookup(logic [DATA_W-1:0] b2);
			int unsigned   n, hi, lo, base, k;
			longint        num, den, slope, dx, delta, sum;
			longint unsigned q, p;
			bit            neg, clipped;
			curve_result_t r;
			n = points_in_use();
			clipped = 1'b0;
			if (flux_tab[n-1] <= b2) begin
				hi = n - 1;
				lo = n - 2;
				base = hi;
			end else if (b2 < flux_tab[0]) begin
				hi = 1;
				lo = 0;
				base = 0;
			end else begin
				k = 1;
				while (k < n && b2 >= flux_tab[k])
					k++;
				hi = (k < n) ? k : n - 1;
				lo = hi - 1;
				base = lo;
			end
			num = widen(reluct_tab[hi]) - widen(reluct_tab[lo]);
			den = widen(flux_tab[hi]) - widen(flux_tab[lo]);
			if (den == 0) begin
				// zero-width segment: flat, flagged
				clipped = 1'b1;
				slope = 0;
				sum = clip32(widen(reluct_tab[base]), clipped);
			end else begin
				q = (magnitude(num) << FRAC_BITS) / magnitude(den);
				neg = (num < 0) != (den < 0);
				slope = clip32(neg ? -longint'(q) : longint'(q), clipped);
				dx = widen(b2) - widen(flux_tab[base]);
				p = (magnitude(slope) * magnitude(dx)) >> FRAC_BITS;
				neg = (slope < 0) != (dx < 0);
				delta = neg ? -longint'(p) : longint'(p);
				sum = clip32(widen(reluct_tab[base]) + delta, clipped);
			end
			r.value = sum[DATA_W-1:0];
			r.slope = slope[DATA_W-1:0];
			r.seg = hi[SEG_W-1:0];
			r.sat = clipped;
			return r;
		endfunction

		function void note_beat(plc_req_t r);
			if (r.req_type == REQ_LOAD) begin
				flux_tab[r.point_index] = r.point_flux_sq;
				reluct_tab[r.point_index] = r.point_reluct;
			end else begin
				expected_lookups.push_back(lookup(r.query_flux_sq));
			end
		endfunction

		function void check_lookup(curve_result_t got);
			curve_result_t want;
			if (expected_lookups.size() == 0) begin
				$display("%0t: result with none pending: value %0d slope %0d seg %0d sat %0b",
					$time, got.value, got.slope, got.seg, got.sat);
				mismatches++;
				return;
			end
			want = expected_lookups.pop_front();
			if (got.value !== want.value) begin
				$display("%0t: reluct_value expected %0d got %0d", $time, want.value, got.value);
				mismatches++;
			end
			if (got.slope !== want.slope) begin
				$display("%0t: reluct_slope expected %0d got %0d", $time, want.slope, got.slope);
				mismatches++;
			end
			if (got.seg !== want.seg) begin
				$display("%0t: segment_used expected %0d got %0d", $time, want.seg, got.seg);
				mismatches++;
			end
			if (got.sat !== want.sat) begin
				$display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;

	plc_in_if  in_ch();
	plc_out_if out_ch();
	plc_cfg_if cfg_ch();

	reluct_curve_predictor curve_pred = new();

	piecewise_linear_curve_lookup u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		curve_result_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.value = out_ch.reluct_value;
			got.slope = out_ch.reluct_slope;
			got.seg = out_ch.segment_used;
			got.sat = out_ch.saturated;
			curve_pred.check_lookup(got);
		end
	end

	// Present one beat, with an optional idle gap first, and hold until it is taken.
	task automatic send_beat(input plc_req_t r);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_ch.req_type = r.req_type;
		in_ch.point_index = r.point_index;
		in_ch.point_flux_sq = r.point_flux_sq;
		in_ch.point_reluct = r.point_reluct;
		in_ch.query_flux_sq = r.query_flux_sq;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		curve_pred.note_beat(r);
	endtask

	task automatic load_point(input int unsigned idx, input logic [DATA_W-1:0] flux,
		input logic [DATA_W-1:0] reluct);
		plc_req_t r;
		r.req_type = REQ_LOAD;
		r.point_index = idx[PIDX_W-1:0];
		r.point_flux_sq = flux;
		r.point_reluct = reluct;
		r.query_flux_sq = $urandom;
		send_beat(r);
	endtask

	task automatic query_flux(input logic [DATA_W-1:0] b2);
		plc_req_t r;
		r.req_type = REQ_QUERY;
		r.point_index = PIDX_W'($urandom);
		r.point_flux_sq = $urandom;
		r.point_reluct = $urandom;
		r.query_flux_sq = b2;
		send_beat(r);
	endtask

	// Write a well-formed curve: rising flux with mixed step sizes, the odd flat step.
	task automatic load_curve(input int unsigned npts);
		longint unsigned flux_acc, rel_acc;
		bit              rising_reluct;
		int unsigned     k, pick;
		logic [DATA_W-1:0] flux, reluct;
		case ($urandom_range(0, 3))
			0: flux_acc = 0;
			1: flux_acc = $urandom_range(0, 255);
			2: flux_acc = $urandom >> 4;
			default: flux_acc = $urandom;
		endcase
		rel_acc = $urandom_range(0, 1 << 20);
		rising_reluct = ($urandom_range(0, 2) != 0);
		for (k = 0; k < npts; k++) begin
			flux = (flux_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : flux_acc[DATA_W-1:0];
			if (rising_reluct)
				reluct = (rel_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rel_acc[DATA_W-1:0];
			else
				reluct = $urandom;
			load_point(k, flux, reluct);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				flux_acc += 0;
			else if (pick < 50)
				flux_acc += $urandom_range(1, 255);
			else if (pick < 90)
				flux_acc += $urandom_range(1, 1 << 20);
			else
				flux_acc += $urandom >> 4;
			rel_acc += $urandom_range(0, 1 << 22);
		end
	endtask

	task automatic random_query();
		int unsigned       n, k, pick;
		logic [DATA_W-1:0] lo_f, hi_f, b2;
		n = curve_pred.points_in_use();
		k = $urandom_range(0, n - 1);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			b2 = curve_pred.flux_tab[k] + $urandom_range(0, 4) - 2;
		end else if (pick < 65) begin
			lo_f = curve_pred.flux_tab[k];
			hi_f = (k < n - 1) ? curve_pred.flux_tab[k+1] : lo_f;
			b2 = (hi_f > lo_f) ? lo_f + $urandom_range(0, hi_f - lo_f - 1) : lo_f;
		end else if (pick < 85) begin
			b2 = $urandom;
		end else begin
			case ($urandom_range(0, 3))
				0: b2 = '0;
				1: b2 = '1;
				2: b2 = curve_pred.flux_tab[0] - 1;
				default: b2 = curve_pred.flux_tab[n-1];
			endcase
		end
		query_flux(b2);
	endtask

	task automatic random_load();
		int unsigned       n, idx;
		logic [DATA_W-1:0] lo_f, hi_f, flux;
		n = curve_pred.points_in_use();
		idx = $urandom_range(0, TABLE_DEPTH - 1);
		flux = $urandom;
		if ($urandom_range(0, 99) < 60 && idx >= 1 && idx + 1 < n) begin
			// keep the curve ordered: land between the neighbors
			lo_f = curve_pred.flux_tab[idx-1];
			hi_f = curve_pred.flux_tab[idx+1];
			if (hi_f >= lo_f)
				flux = lo_f + $urandom_range(0, hi_f - lo_f);
		end
		load_point(idx, flux, $urandom);
	endtask

	// Drop valid, wait out every pending result and the block's tail latency.
	task automatic drain_block();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (curve_pred.expected_lookups.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_ch.point_count = v;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		curve_pred.set_point_count(v);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned      phase, issued, n_eff, pick;
		logic [CNT_W-1:0] count_val;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_QUERY;
		in_ch.point_index = '0;
		in_ch.point_flux_sq = '0;
		in_ch.point_reluct = '0;
		in_ch.query_flux_sq = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.point_count = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: two points in use after reset
		load_point(0, 32'h0001_0000, 32'h0010_0000);
		load_point(1, 32'h0003_0000, 32'h0030_0000);
		query_flux(32'h0000_0000);
		query_flux(32'h0001_0000);
		query_flux(32'h0002_8000);
		query_flux(32'h0003_0000);
		query_flux(32'hFFFF_FFFF);
		// steep segment: slope clips
		load_point(1, 32'h0001_0001, 32'hFFFF_FFFF);
		query_flux(32'h0001_0000);
		// falling segment: value clips low far out
		load_point(1, 32'h0002_0000, 32'h0000_0000);
		query_flux(32'hFFFF_FFFF);
		query_flux(32'h0000_0000);
		// zero-width segment with a base reluctivity above the signed range
		load_point(1, 32'h0001_0000, 32'h8000_0000);
		query_flux(32'h0001_0000);
		query_flux(32'h0000_0001);
		load_point(0, 32'h0000_0000, 32'hFFFF_FFFF);
		load_point(1, 32'hFFFF_FFFF, 32'h0000_0000);
		query_flux(32'h8000_0000);
		query_flux(32'hFFFF_FFFF);
		load_point(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		query_flux(32'h0000_0000);

		for (phase = 0; phase < 9; phase++) begin
			drain_block();
			case (phase)
				0: count_val = CNT_W'(64);
				1: count_val = CNT_W'(2);
				2: count_val = '1;
				3: count_val = '0;
				4: count_val = CNT_W'(1);
				5: count_val = CNT_W'(65);
				8: count_val = CNT_W'(64);
				default: count_val = CNT_W'($urandom_range(3, TABLE_DEPTH - 1));
			endcase
			write_point_count(count_val);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			n_eff = curve_pred.points_in_use();
			load_curve(n_eff);
			issued = 0;
			while (issued < 30) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					load_curve(n_eff);
					issued += n_eff;
				end else if (pick < 20) begin
					random_load();
					issued++;
				end else begin
					random_query();
					issued++;
				end
			end
		end

		drain_block();
		if (curve_pred.mismatches == 0 && curve_pred.expected_lookups.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/plc_pkg.sv
hw/rtl/plc_if.sv
hw/rtl/plc_div.sv
hw/rtl/plc_datapath.sv
hw/rtl/plc_ctrl.sv
hw/rtl/piecewise_linear_curve_lookup.sv
bench/piecewise_linear_curve_lookup_test.sv
